### sv/vector_magnitude_3axis_unit_defines.svh
// Assertion macros shared by the checker of the vector magnitude unit.
`ifndef VECTOR_MAGNITUDE_3AXIS_UNIT_DEFINES_SVH
`define VECTOR_MAGNITUDE_3AXIS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VM3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vm3 check failed");

// Next-cycle implication, disabled during reset.
`define VM3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vm3 check failed");

`endif

### sv/vm3_pkg.sv
// Shared widths and the inter-cell bus type of the vector magnitude unit.
package vm3_pkg;

  localparam int AXIS_W     = 16;
  localparam int SQ_W       = 32;
  localparam int LEN_W      = 16;
  localparam int ROOT_STEPS = SQ_W / 2;
  // Partial remainder stays at or below twice the partial root.
  localparam int REM_W      = LEN_W + 2;
  // Root is kept doubled between steps.
  localparam int ROOT_W     = LEN_W + 2;

  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   sq;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } cell_bus_t;

endpackage

### sv/vm3_if.sv
// Valid/ready channel interfaces for samples in and magnitudes out.
interface vm3_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vm3_pkg::AXIS_W-1:0]  x_axis;
  logic signed [vm3_pkg::AXIS_W-1:0]  y_axis;
  logic signed [vm3_pkg::AXIS_W-1:0]  z_axis;

  modport source (output valid, output x_axis, output y_axis, output z_axis, input ready);
  modport sink   (input valid, input x_axis, input y_axis, input z_axis, output ready);
endinterface

interface vm3_out_if;
  logic                        valid;
  logic                        ready;
  logic [vm3_pkg::SQ_W-1:0]    squared_length;
  logic [vm3_pkg::LEN_W-1:0]   length;

  modport source (output valid, output squared_length, output length, input ready);
  modport sink   (input valid, input squared_length, input length, output ready);
endinterface

### sv/vector_magnitude_3axis_unit.sv
// Pipeline: 18 register stages (2 square/sum + 16 root cells), the first loaded
// at the edge that takes the sample transaction.
// Throughput: one sample per cycle; the whole pipe advances together and holds
// only while a finished result sits unconsumed in the last cell.
// Each root cell resolves one result bit, so the 16-cell chain sets the latency.
// Reset (synchronous, active high) clears all stage valid bits; no data is kept.
module vector_magnitude_3axis_unit (
  input  logic             clk,
  input  logic             rst,
  vm3_in_if.sink           sample,
  vm3_out_if.source        result
);

  localparam int STEPS = vm3_pkg::ROOT_STEPS;

  vm3_pkg::cell_bus_t chain [STEPS+1];
  logic               adv;

  // Move every stage when the last one is empty or being drained.
  assign adv          = !chain[STEPS].valid || result.ready;
  assign sample.ready = adv;

  vm3_square_sum u_sqsum (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (sample.valid),
    .x_axis   (sample.x_axis),
    .y_axis   (sample.y_axis),
    .z_axis   (sample.z_axis),
    .bus      (chain[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    vm3_root_cell #(
      .STEP (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .in_bus  (chain[i]),
      .out_bus (chain[i+1])
    );
  end

  assign result.valid          = chain[STEPS].valid;
  assign result.squared_length = chain[STEPS].sq;
  assign result.length         = chain[STEPS].root[vm3_pkg::LEN_W:1];

endmodule

### sv/vm3_square_sum.sv
// Two-stage front end: square each axis, then add the three squares.
module vm3_square_sum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [vm3_pkg::AXIS_W-1:0] x_axis,
  input  logic signed [vm3_pkg::AXIS_W-1:0] y_axis,
  input  logic signed [vm3_pkg::AXIS_W-1:0] z_axis,
  output vm3_pkg::cell_bus_t                bus
);

  localparam int PROD_W = 2 * vm3_pkg::AXIS_W;

  logic              prod_valid;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] prod_z;
  logic              sum_valid;
  logic [vm3_pkg::SQ_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else if (adv) begin
      prod_valid <= in_valid;
      sum_valid  <= prod_valid;
    end
  end

  // Signed squares are never negative; -32768 squared is 2^30 and fits.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x <= PROD_W'($signed(x_axis) * $signed(x_axis));
      prod_y <= PROD_W'($signed(y_axis) * $signed(y_axis));
      prod_z <= PROD_W'($signed(z_axis) * $signed(z_axis));
      sum    <= vm3_pkg::SQ_W'(prod_x + prod_y + prod_z);
    end
  end

  always_comb begin
    bus.valid = sum_valid;
    bus.sq    = sum;
    bus.rem   = '0;
    bus.root  = '0;
  end

endmodule

### sv/vm3_root_cell.sv
// One restoring square-root step: brings down one bit pair of the sum.
module vm3_root_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  vm3_pkg::cell_bus_t in_bus,
  output vm3_pkg::cell_bus_t out_bus
);

  localparam int REM_W  = vm3_pkg::REM_W;
  localparam int ROOT_W = vm3_pkg::ROOT_W;
  localparam int PAIR_HI = vm3_pkg::SQ_W - 1 - 2 * STEP;

  logic [REM_W+1:0]  rem_sh;
  logic [ROOT_W-1:0] root_sh;
  logic              take;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;

  always_comb begin
    rem_sh  = {in_bus.rem, in_bus.sq[PAIR_HI -: 2]};
    root_sh = {in_bus.root[ROOT_W-2:0], 1'b0};
    take    = {2'b00, root_sh} < rem_sh;
    if (take) begin
      rem_next  = REM_W'(rem_sh - {2'b00, root_sh | ROOT_W'(1)});
      root_next = root_sh + ROOT_W'(2);
    end else begin
      rem_next  = rem_sh[REM_W-1:0];
      root_next = root_sh;
    end
  end

  // Only the valid bit is reset; data follows it down the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_bus.valid <= 1'b0;
    end else if (adv) begin
      out_bus.valid <= in_bus.valid;
    end
    if (adv) begin
      out_bus.sq   <= in_bus.sq;
      out_bus.rem  <= rem_next;
      out_bus.root <= root_next;
    end
  end

endmodule

### sv/vm3_checker.sv
// Port-level checks for the vector magnitude unit, bound to the top level.
`include "vector_magnitude_3axis_unit_defines.svh"

module vm3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vm3_pkg::SQ_W-1:0]   squared_length,
  input logic [vm3_pkg::LEN_W-1:0]  length
);

  logic [vm3_pkg::SQ_W:0] len_sq;
  logic [vm3_pkg::SQ_W:0] len1_sq;

  assign len_sq  = (vm3_pkg::SQ_W+1)'({17'd0, length} * {17'd0, length});
  assign len1_sq = (vm3_pkg::SQ_W+1)'(({17'd0, length} + 33'd1) * ({17'd0, length} + 33'd1));

  `VM3_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid)
  `VM3_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)
  `VM3_ASSERT_NOW(a_root_low, out_valid, len_sq <= {1'b0, squared_length})
  `VM3_ASSERT_NOW(a_root_high, out_valid, len1_sq > {1'b0, squared_length})

endmodule

bind vector_magnitude_3axis_unit vm3_checker u_vm3_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (sample.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .squared_length (result.squared_length),
  .length         (result.length)
);

### bench/vm3_magnitude_checker.sv
// Checker for the vector magnitude unit: predicts each magnitude and compares results.
module vm3_magnitude_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  input  logic                               sample_ready,
  input  logic signed [vm3_pkg::AXIS_W-1:0]  x_axis,
  input  logic signed [vm3_pkg::AXIS_W-1:0]  y_axis,
  input  logic signed [vm3_pkg::AXIS_W-1:0]  z_axis,
  input  logic                               result_valid,
  input  logic                               result_ready,
  input  logic [vm3_pkg::SQ_W-1:0]           squared_length,
  input  logic [vm3_pkg::LEN_W-1:0]          length,
  output int unsigned                        mismatch_count,
  output int unsigned                        magnitudes_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [vm3_pkg::SQ_W-1:0]  squared_length;
    logic [vm3_pkg::LEN_W-1:0] length;
  } magnitude_t;

  magnitude_t expected_magnitudes[$];
  magnitude_t oldest_magnitude;
  int unsigned result_index;

  initial begin
    mismatch_count = 0;
    magnitudes_outstanding = 0;
    result_index = 0;
  end

  // Absolute value widened to 17 bits so that -32768 maps to 32768.
  function automatic logic [vm3_pkg::AXIS_W:0] axis_abs(
      input logic signed [vm3_pkg::AXIS_W-1:0] v);
    logic [vm3_pkg::AXIS_W:0] ext;
    ext = {v[vm3_pkg::AXIS_W-1], v};
    if (v[vm3_pkg::AXIS_W-1]) begin
      return ~ext + 1'b1;
    end
    return ext;
  endfunction

  function automatic magnitude_t predict_magnitude(
      input logic signed [vm3_pkg::AXIS_W-1:0] x,
      input logic signed [vm3_pkg::AXIS_W-1:0] y,
      input logic signed [vm3_pkg::AXIS_W-1:0] z);
    logic [vm3_pkg::AXIS_W:0]  ax;
    logic [vm3_pkg::AXIS_W:0]  ay;
    logic [vm3_pkg::AXIS_W:0]  az;
    logic [vm3_pkg::SQ_W-1:0]  sum;
    logic [vm3_pkg::LEN_W-1:0] root;
    logic [vm3_pkg::LEN_W-1:0] trial;
    magnitude_t                m;
    ax = axis_abs(x);
    ay = axis_abs(y);
    az = axis_abs(z);
    sum = ax * ax + ay * ay + az * az;
    // Greedy floor root: keep each bit whose trial square stays within the sum.
    root = '0;
    for (int b = vm3_pkg::LEN_W - 1; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (33'(trial) * 33'(trial) <= 33'(sum)) begin
        root = trial;
      end
    end
    m.squared_length = sum;
    m.length = root;
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns ERROR result %0d: %s", $time, result_index, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_magnitudes.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction sq=%0d len=%0d",
                                    squared_length, length));
        end else begin
          oldest_magnitude = expected_magnitudes.pop_front();
          if (squared_length !== oldest_magnitude.squared_length) begin
            report_mismatch($sformatf("squared_length %0d, want %0d",
                                      squared_length, oldest_magnitude.squared_length));
          end
          if (length !== oldest_magnitude.length) begin
            report_mismatch($sformatf("length %0d, want %0d",
                                      length, oldest_magnitude.length));
          end
        end
        result_index++;
      end
      if (sample_valid && sample_ready) begin
        expected_magnitudes.push_back(predict_magnitude(x_axis, y_axis, z_axis));
      end
      magnitudes_outstanding = expected_magnitudes.size();
    end
  end

endmodule

### bench/testbench.sv
// Top of the vector magnitude unit bench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF          = 10;
  localparam int RESET_CYCLES      = 4;
  localparam int SAMPLES_PER_PHASE = 612;
  localparam int PHASES            = 3;
  // Pipe is 18 deep; leave a wide margin for stray results.
  localparam int DRAIN_CYCLES      = 60;
  localparam int STALL_LIMIT       = 2000;
  localparam int SEND_IDLE[PHASES] = '{15, 72, 0};
  localparam int RECV_IDLE[PHASES] = '{72, 15, 0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned magnitudes_outstanding;
  int unsigned quiet_cycles = 0;

  vm3_in_if  sample_ch ();
  vm3_out_if result_ch ();

  vector_magnitude_3axis_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  vm3_magnitude_checker i_checker (
    .clk                    (clk),
    .rst                    (rst),
    .sample_valid           (sample_ch.valid),
    .sample_ready           (sample_ch.ready),
    .x_axis                 (sample_ch.x_axis),
    .y_axis                 (sample_ch.y_axis),
    .z_axis                 (sample_ch.z_axis),
    .result_valid           (result_ch.valid),
    .result_ready           (result_ch.ready),
    .squared_length         (result_ch.squared_length),
    .length                 (result_ch.length),
    .mismatch_count         (mismatch_count),
    .magnitudes_outstanding (magnitudes_outstanding)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ch.ready = !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles since the last transaction on either channel.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t ns ERROR no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("vector_magnitude_3axis_unit: mismatch");
    $finish;
  end

  task automatic send_sample(input logic signed [vm3_pkg::AXIS_W-1:0] x,
                             input logic signed [vm3_pkg::AXIS_W-1:0] y,
                             input logic signed [vm3_pkg::AXIS_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid  = 1'b1;
    sample_ch.x_axis = x;
    sample_ch.y_axis = y;
    sample_ch.z_axis = z;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted magnitude has come back.
  task automatic pause_until_drained();
    sample_ch.valid = 1'b0;
    while (magnitudes_outstanding != 0) @(negedge clk);
  endtask

  function automatic logic signed [vm3_pkg::AXIS_W-1:0] random_axis();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd1;
          3: return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      1, 2: return 16'($signed($urandom_range(63)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    sample_ch.valid  = 1'b0;
    sample_ch.x_axis = '0;
    sample_ch.y_axis = '0;
    sample_ch.z_axis = '0;
    result_ch.ready  = 1'b0;
    send_idle_pct    = SEND_IDLE[0];
    recv_idle_pct    = RECV_IDLE[0];
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, exact squares and their neighbors, two-axis use.
    send_sample(0, 0, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(-1, -1, -1);
    send_sample(1, 0, 0);
    send_sample(-32768, 0, 0);
    send_sample(0, -32768, 0);
    send_sample(0, 0, -32768);
    send_sample(-32768, -32768, 0);
    send_sample(32767, -32768, 1);
    send_sample(3, 4, 0);
    send_sample(3, 4, 1);
    send_sample(2, -3, 6);
    send_sample(2, 3, -5);
    send_sample(16'sh5555, -16'sh5556, 16'sh7FFE);
    send_sample(-256, 255, 0);
    send_sample(-32767, 32767, -32767);
    pause_until_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      recv_idle_pct = RECV_IDLE[phase];
      for (int i = 0; i < SAMPLES_PER_PHASE; i++) begin
        if ($urandom_range(99) == 0) begin
          pause_until_drained();
        end
        // One sample in five is two-axis.
        send_sample(random_axis(), random_axis(),
                    ($urandom_range(4) == 0) ? 16'sd0 : random_axis());
      end
      pause_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && magnitudes_outstanding == 0) begin
      $display("vector_magnitude_3axis_unit: match");
    end else begin
      $display("vector_magnitude_3axis_unit: mismatch");
    end
    $finish;
  end

endmodule
